/* hdl/minmod_surface_reconstruction_unit_macros.svh */
// Assertion macros used by the checker file of the reconstruction unit.
`ifndef MINMOD_SURFACE_RECONSTRUCTION_UNIT_MACROS_SVH
`define MINMOD_SURFACE_RECONSTRUCTION_UNIT_MACROS_SVH

// Property sampled on clk and ignored while reset is asserted.
`define MMSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property sampled on clk that also covers the reset cycles.
`define MMSR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mmsr_pkg.sv */
// Types and constants shared by the minmod surface reconstruction modules.
package mmsr_pkg;

  localparam int DW   = 32;      // sample and result width
  localparam int SLW  = DW + 1;  // slope width
  localparam int SUMW = DW + 2;  // width of a depth plus surface slope
  localparam int DIFW = DW + 3;  // width of the limited difference and the unsaturated sum

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] depth;
    logic signed [DW-1:0] surface;
    logic                 first_in_row;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] left_value;
    logic                 clipped;
  } out_item_t;

  // One reconstruction job: the middle surface sample and the slopes around it.
  typedef struct packed {
    logic signed [DW-1:0]  z_mid;
    logic signed [SLW-1:0] dh1;
    logic signed [SLW-1:0] dz1;
    logic signed [SLW-1:0] dh2;
    logic signed [SLW-1:0] dz2;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* hdl/minmod_surface_reconstruction_unit.sv */
// Top level of the minmod surface reconstruction unit.
//
// Samples arrive on the input queue port: an item transfers on a clock edge with
// push high and full low. Each item carries a depth, a surface height and a
// first_in_row flag; a row needs three samples before the first result, and every
// later sample of the row yields the left-face value of the sample before it.
// Results leave on the output queue port: the oldest result is shown while empty
// is low and transfers on an edge with pop high.
// Throughput is one sample per cycle while full is low. The job of the sample
// that completes a result is written to the job queue and then passes through
// the three limiter stages behind it. When pop is held low the result register
// keeps its value, the limiter stalls, and the job queue of QUEUE_DEPTH entries
// keeps taking samples until it fills; full then holds off the sender. Samples
// that yield no result never occupy the queue.
// Synchronous reset empties the queue and the pipeline and closes the current
// row, so the next sample starts a row whether flagged or not.
module minmod_surface_reconstruction_unit
  import mmsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  q_status_t q_stat;
  logic      job_push;
  logic      job_pop;
  work_t     job_in;
  work_t     job_out;

  mmsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .full     (full),
    .job_push (job_push),
    .job      (job_in)
  );

  mmsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .stat    (q_stat)
  );

  mmsr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .job      (job_out),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

/* hdl/mmsr_front.sv */
// Front end: takes samples, tracks the row window and issues reconstruction jobs.
module mmsr_front
  import mmsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_item_t  in_item,
  input  q_status_t q_stat,
  output logic      full,
  output logic      job_push,
  output work_t     job
);

  logic signed [DW-1:0]  last_depth_r, last_depth_nxt;
  logic signed [DW-1:0]  last_surface_r, last_surface_nxt;
  logic signed [SLW-1:0] last_dh_r, last_dh_nxt;
  logic signed [SLW-1:0] last_dz_r, last_dz_nxt;
  logic [1:0]            seen_r, seen_nxt;

  logic                  accept;
  logic                  row_start;
  logic signed [SLW-1:0] dh2;
  logic signed [SLW-1:0] dz2;

  assign full      = q_stat.full;
  assign accept    = push && !q_stat.full;
  // A sample with no row open yet starts a row, flagged or not.
  assign row_start = in_item.first_in_row || (seen_r == 2'd0);
  assign dh2       = SLW'(in_item.depth) - SLW'(last_depth_r);
  assign dz2       = SLW'(in_item.surface) - SLW'(last_surface_r);

  assign job_push  = accept && !row_start && seen_r[1];
  assign job.z_mid = last_surface_r;
  assign job.dh1   = last_dh_r;
  assign job.dz1   = last_dz_r;
  assign job.dh2   = dh2;
  assign job.dz2   = dz2;

  always_comb begin
    last_depth_nxt   = last_depth_r;
    last_surface_nxt = last_surface_r;
    last_dh_nxt      = last_dh_r;
    last_dz_nxt      = last_dz_r;
    seen_nxt         = seen_r;
    if (accept) begin
      last_depth_nxt   = in_item.depth;
      last_surface_nxt = in_item.surface;
      if (row_start) begin
        last_dh_nxt = '0;
        last_dz_nxt = '0;
        seen_nxt    = 2'd1;
      end else begin
        last_dh_nxt = dh2;
        last_dz_nxt = dz2;
        seen_nxt    = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_depth_r   <= last_depth_nxt;
    last_surface_r <= last_surface_nxt;
    last_dh_r      <= last_dh_nxt;
    last_dz_r      <= last_dz_nxt;
  end

endmodule

/* hdl/mmsr_queue.sv */
// Job queue between the front end and the limiter pipeline.
module mmsr_queue
  import mmsr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  work_t     wr_data,
  input  logic      rd_en,
  output work_t     rd_data,
  output q_status_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t         slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/mmsr_back.sv */
// Back end: three-stage minmod limiter, halving, saturation and result register.
module mmsr_back
  import mmsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  work_t     job,
  output logic      job_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  function automatic logic signed [SUMW-1:0] minmod(input logic signed [SUMW-1:0] a,
                                                    input logic signed [SUMW-1:0] b);
    logic signed [SUMW-1:0] r;
    if (a >= 0 && b >= 0) begin
      r = (a <= b) ? a : b;
    end else if (a <= 0 && b <= 0) begin
      r = (a >= b) ? a : b;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  localparam logic signed [DIFW-1:0] VMAX = DIFW'(SAT_MAX);
  localparam logic signed [DIFW-1:0] VMIN = DIFW'(SAT_MIN);

  // The whole pipeline moves whenever the result register is free or being drained.
  logic adv;

  logic                   s1_valid_r, s1_valid_nxt;
  logic signed [DW-1:0]   s1_z_r;
  logic signed [SUMW-1:0] s1_sum1_r;
  logic signed [SUMW-1:0] s1_sum2_r;
  logic signed [SUMW-1:0] s1_mmh_r;

  logic                   s2_valid_r, s2_valid_nxt;
  logic signed [DW-1:0]   s2_z_r;
  logic signed [DIFW-1:0] s2_diff_r;

  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r;

  logic signed [DIFW-1:0] half;
  logic signed [DIFW-1:0] val;
  out_item_t              res;

  assign adv      = !out_valid_r || pop;
  assign job_pop  = adv && !q_stat.empty;
  assign empty    = !out_valid_r;
  assign out_item = out_r;

  assign s1_valid_nxt  = adv ? !q_stat.empty : s1_valid_r;
  assign s2_valid_nxt  = adv ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = adv ? s2_valid_r : out_valid_r;

  assign half = s2_diff_r >>> 1;
  assign val  = DIFW'(s2_z_r) + half;

  always_comb begin
    priority if (val > VMAX) begin
      res.left_value = SAT_MAX;
      res.clipped    = 1'b1;
    end else if (val < VMIN) begin
      res.left_value = SAT_MIN;
      res.clipped    = 1'b1;
    end else begin
      res.left_value = val[DW-1:0];
      res.clipped    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_z_r    <= job.z_mid;
      s1_sum1_r <= SUMW'(job.dz1) + SUMW'(job.dh1);
      s1_sum2_r <= SUMW'(job.dz2) + SUMW'(job.dh2);
      s1_mmh_r  <= minmod(SUMW'(job.dh1), SUMW'(job.dh2));
      s2_z_r    <= s1_z_r;
      s2_diff_r <= DIFW'(minmod(s1_sum1_r, s1_sum2_r)) - DIFW'(s1_mmh_r);
      out_r     <= res;
    end
  end

endmodule

/* hdl/mmsr_checker.sv */
// Port-level checker for the reconstruction unit and its bind statement.
`include "minmod_surface_reconstruction_unit_macros.svh"

module mmsr_checker
  import mmsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input in_item_t  in_item,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  logic stalled;
  logic on_rail;

  assign stalled = !empty && !pop;
  assign on_rail = (out_item.left_value == SAT_MAX) || (out_item.left_value == SAT_MIN);

  // Reset leaves both queues idle.
  `MMSR_ASSERT_RST(a_reset_idle, !rst_n |=> (empty && !full), "ports not idle after reset")

  // A row needs three samples, so no result can show in the first cycles after reset.
  `MMSR_ASSERT_RST(a_no_early_result, (!rst_n ##1 rst_n) |=> empty, "result too soon after reset")

  // A waiting result holds until it transfers.
  `MMSR_ASSERT(a_result_holds, stalled |=> (!empty && $stable(out_item)), "result not held")

  // A clipped result sits on one of the two rails.
  `MMSR_ASSERT(a_clip_rail, (!empty && out_item.clipped) |-> on_rail, "clipped result off rail")

endmodule

bind minmod_surface_reconstruction_unit mmsr_checker u_mmsr_checker (.*);
